/* hdl/first_fit_heap_allocator_defines.svh */
// Assertion macros shared by the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ffha_pkg.sv */
// Types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

   localparam int ADDR_W = 21;
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_CALLOC  = 2'd1,
      OP_FREE    = 2'd2,
      OP_REALLOC = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOMEM    = 3'd1,
      ST_ZERO     = 3'd2,
      ST_INVALID  = 3'd3,
      ST_DOUBLE   = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef struct packed {
      op_type              req_type;
      logic [WORD_W-1:0]   size;
      logic [WORD_W-1:0]   alignment;
      logic [WORD_W-1:0]   count;
      logic [ADDR_W-1:0]   address;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      status_type          status;
      logic [ADDR_W-1:0]   granted_size;
      logic [WORD_W-1:0]   alloc_count;
      logic [WORD_W-1:0]   release_count;
      logic [WORD_W-1:0]   fail_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   offset;
      logic [ADDR_W-1:0]   size;
      logic                free;
   } seg_type;

   typedef struct packed {
      logic [WORD_W:0]     rounded;
      logic [WORD_W+1:0]   need;
      logic                zero;
      logic                ovf;
   } prep_type;

   typedef enum logic {
      PH_ALLOC,
      PH_FIND
   } phase_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP1,
      S_PREP2,
      S_PREP3,
      S_DECIDE,
      S_SCAN,
      S_SPLIT_CHK,
      S_COPY,
      S_WR_NEW,
      S_WR_OLD,
      S_CHECK,
      S_MARK,
      S_BK_RD,
      S_BK_CHK,
      S_FW_RD,
      S_FW_CHK,
      S_MERGE,
      S_FREE_END,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

/* hdl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer, segment walks and counters.
//
//  Channel | Ports                          | Moves
//  --------+--------------------------------+----------------------------------
//  request | req_valid req_ready req_item   | one request item
//  result  | rsp_valid rsp_ready rsp_item   | one result item per request
//
// One item is taken at a time; req_ready is high only while the sequencer is idle.
// An item is prepared, then the segment table is scanned entry by entry; on a split or merge
// entries are moved one at a time, and on a free each neighbor is read and checked; a growing
// realloc runs both an allocation and a free.
// Reset is synchronous and leaves one free segment over the whole heap, with no sweep.
// A result waits in the output register while rsp_ready is low; the next result waits in the done state.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES     = 1048576,
   parameter int HEADER_BYTES   = 32,
   parameter int DEFAULT_ALIGN  = 16,
   parameter int MAX_SEGMENTS   = 64,
   parameter int MIN_SPLIT_DATA = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::rsp_item_type rsp_item
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = ffha_pkg::ADDR_W;
   localparam int W  = ffha_pkg::WORD_W;
   localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

   ffha_pkg::state_type    state_ff, state_in;
   ffha_pkg::phase_type    phase_ff, phase_in;
   ffha_pkg::req_item_type req_ff, req_in;
   ffha_pkg::seg_type      e_ff, e_in;
   ffha_pkg::status_type   res_st_ff, res_st_in;
   ffha_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   ffha_pkg::prep_type     prep;
   ffha_pkg::seg_type      rd_data, wr_data;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   grow_ff, grow_in, split_ff, split_in;
   logic [CW-1:0]          ip_ff, ip_in, count_ff, count_in;
   logic                   dv_ff, dv_in;
   logic [IW-1:0]          dp_ff, dp_in, i_ff, i_in, a_ff, a_in, b_ff, b_in, gap_ff, gap_in;
   logic [IW-1:0]          src_ff, src_in, last_ff, last_in, dst_ff, dst_in;
   logic                   dir_up_ff, dir_up_in, more_ff, more_in, pend_ff, pend_in;
   logic [AW-1:0]          a_off_ff, a_off_in, b_end_ff, b_end_in;
   logic [AW-1:0]          res_addr_ff, res_addr_in, res_gr_ff, res_gr_in;
   logic [W-1:0]           allocs_ff, allocs_in, frees_ff, frees_in, fails_ff, fails_in;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr, rd_addr;
   logic                   scan_issue, scan_hit, scan_miss, split_now, copy_up_needed;
   logic                   down_needed, resize_path, fits, out_free;

   ffha_prep #(
      .HEADER_BYTES  (HEADER_BYTES),
      .DEFAULT_ALIGN (DEFAULT_ALIGN),
      .MIN_SPLIT_DATA(MIN_SPLIT_DATA)
   ) u_prep (
      .clock(clock),
      .req  (req_ff),
      .prep (prep)
   );

   ffha_seg_ram #(
      .DEPTH     (MAX_SEGMENTS),
      .RESET_SIZE(AW'(HEAP_BYTES - HEADER_BYTES))
   ) u_ram (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign scan_issue = (ip_ff < count_ff);
   assign scan_hit   = dv_ff && ((phase_ff == ffha_pkg::PH_ALLOC) ?
                       (rd_data.free && ({12'b0, rd_data.size} >= prep.rounded)) :
                       (({1'b0, rd_data.offset} + {1'b0, HDR}) == {1'b0, req_ff.address}));
   assign scan_miss  = !dv_ff && !scan_issue;
   assign split_now  = ({13'b0, e_ff.size} >= prep.need) &&
                       (count_ff < CW'(MAX_SEGMENTS));
   assign copy_up_needed = ((CW'(i_ff) + CW'(1)) < count_ff);
   assign down_needed    = ((CW'(b_ff) + CW'(1)) < count_ff);
   assign resize_path    = (req_ff.req_type == ffha_pkg::OP_REALLOC) && !grow_ff &&
                           (req_ff.size != '0);
   assign fits           = (req_ff.size <= {11'b0, e_ff.size});
   assign out_free       = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::S_IDLE:    if (req_valid) state_in = ffha_pkg::S_PREP1;
         ffha_pkg::S_PREP1:   state_in = ffha_pkg::S_PREP2;
         ffha_pkg::S_PREP2:   state_in = ffha_pkg::S_PREP3;
         ffha_pkg::S_PREP3:   state_in = ffha_pkg::S_DECIDE;
         ffha_pkg::S_DECIDE: begin
            case (req_ff.req_type) inside
               ffha_pkg::OP_ALLOC, ffha_pkg::OP_CALLOC:
                  state_in = (prep.ovf || prep.zero) ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN;
               ffha_pkg::OP_FREE:
                  state_in = (req_ff.address == '0) ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN;
               default:
                  state_in = ((req_ff.address == '0) && prep.zero) ? ffha_pkg::S_DONE :
                             ffha_pkg::S_SCAN;
            endcase
         end
         ffha_pkg::S_SCAN: begin
            if (scan_hit) begin
               state_in = (phase_ff == ffha_pkg::PH_ALLOC) ? ffha_pkg::S_SPLIT_CHK :
                          ffha_pkg::S_CHECK;
            end else if (scan_miss) begin
               state_in = ffha_pkg::S_DONE;
            end
         end
         ffha_pkg::S_SPLIT_CHK: begin
            if (!split_now) state_in = ffha_pkg::S_WR_OLD;
            else if (copy_up_needed) state_in = ffha_pkg::S_COPY;
            else state_in = ffha_pkg::S_WR_NEW;
         end
         ffha_pkg::S_COPY: begin
            if (!more_ff && !pend_ff) begin
               state_in = (phase_ff == ffha_pkg::PH_ALLOC) ? ffha_pkg::S_WR_NEW :
                          ffha_pkg::S_FREE_END;
            end
         end
         ffha_pkg::S_WR_NEW:  state_in = ffha_pkg::S_WR_OLD;
         ffha_pkg::S_WR_OLD:  state_in = grow_ff ? ffha_pkg::S_SCAN : ffha_pkg::S_DONE;
         ffha_pkg::S_CHECK: begin
            if (e_ff.free) state_in = ffha_pkg::S_DONE;
            else if (resize_path) state_in = fits ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN;
            else state_in = ffha_pkg::S_MARK;
         end
         ffha_pkg::S_MARK:    state_in = ffha_pkg::S_BK_RD;
         ffha_pkg::S_BK_RD:   state_in = (a_ff == '0) ? ffha_pkg::S_FW_RD : ffha_pkg::S_BK_CHK;
         ffha_pkg::S_BK_CHK:  state_in = rd_data.free ? ffha_pkg::S_BK_RD : ffha_pkg::S_FW_RD;
         ffha_pkg::S_FW_RD:   state_in = down_needed ? ffha_pkg::S_FW_CHK : ffha_pkg::S_MERGE;
         ffha_pkg::S_FW_CHK:  state_in = rd_data.free ? ffha_pkg::S_FW_RD : ffha_pkg::S_MERGE;
         ffha_pkg::S_MERGE:   state_in = ((b_ff > a_ff) && down_needed) ? ffha_pkg::S_COPY :
                                         ffha_pkg::S_FREE_END;
         ffha_pkg::S_FREE_END: state_in = ffha_pkg::S_DONE;
         ffha_pkg::S_DONE:    if (out_free) state_in = ffha_pkg::S_IDLE;
         default:             state_in = ffha_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ffha_pkg::S_IDLE);
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = i_ff;
      wr_data   = e_ff;
      unique case (state_ff)
         ffha_pkg::S_SCAN:  rd_addr = ip_ff[IW-1:0];
         ffha_pkg::S_COPY: begin
            rd_addr = src_ff;
            wr_en   = pend_ff;
            wr_addr = dst_ff;
            wr_data = rd_data;
         end
         ffha_pkg::S_WR_NEW: begin
            wr_en   = 1'b1;
            wr_addr = i_ff + IW'(1);
            wr_data = '{offset: e_ff.offset + HDR + prep.rounded[AW-1:0],
                        size:   e_ff.size - prep.rounded[AW-1:0] - HDR,
                        free:   1'b1};
         end
         ffha_pkg::S_WR_OLD: begin
            wr_en   = 1'b1;
            wr_data = '{offset: e_ff.offset,
                        size:   split_ff ? prep.rounded[AW-1:0] : e_ff.size,
                        free:   1'b0};
         end
         ffha_pkg::S_MARK: begin
            wr_en   = 1'b1;
            wr_data = '{offset: e_ff.offset, size: e_ff.size, free: 1'b1};
         end
         ffha_pkg::S_BK_RD: rd_addr = a_ff - IW'(1);
         ffha_pkg::S_FW_RD: rd_addr = b_ff + IW'(1);
         ffha_pkg::S_MERGE: begin
            wr_en   = (b_ff > a_ff);
            wr_addr = a_ff;
            wr_data = '{offset: a_off_ff, size: b_end_ff - a_off_ff, free: 1'b1};
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      req_in      = req_ff;
      e_in        = e_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      res_gr_in   = res_gr_ff;
      grow_in     = grow_ff;
      split_in    = split_ff;
      ip_in       = ip_ff;
      dv_in       = 1'b0;
      dp_in       = dp_ff;
      i_in        = i_ff;
      count_in    = count_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      gap_in      = gap_ff;
      a_off_in    = a_off_ff;
      b_end_in    = b_end_ff;
      src_in      = src_ff;
      last_in     = last_ff;
      dst_in      = dst_ff;
      dir_up_in   = dir_up_ff;
      more_in     = more_ff;
      pend_in     = 1'b0;
      allocs_in   = allocs_ff;
      frees_in    = frees_ff;
      fails_in    = fails_ff;
      rsp_item_in = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ip_in       = '0;
      case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in      = req_item;
               res_st_in   = ffha_pkg::ST_OK;
               res_addr_in = '0;
               res_gr_in   = '0;
               grow_in     = 1'b0;
            end
         end
         ffha_pkg::S_DECIDE: begin
            case (req_ff.req_type) inside
               ffha_pkg::OP_ALLOC, ffha_pkg::OP_CALLOC: begin
                  if (prep.ovf) begin
                     fails_in  = fails_ff + W'(1);
                     res_st_in = ffha_pkg::ST_OVERFLOW;
                  end else if (prep.zero) begin
                     res_st_in = ffha_pkg::ST_ZERO;
                  end
                  phase_in = ffha_pkg::PH_ALLOC;
               end
               ffha_pkg::OP_FREE: phase_in = ffha_pkg::PH_FIND;
               default: begin
                  if (req_ff.address == '0) begin
                     phase_in = ffha_pkg::PH_ALLOC;
                     if (prep.zero) res_st_in = ffha_pkg::ST_ZERO;
                  end else begin
                     phase_in = ffha_pkg::PH_FIND;
                  end
               end
            endcase
         end
         ffha_pkg::S_SCAN: begin
            if (scan_issue) begin
               dv_in = 1'b1;
               dp_in = ip_ff[IW-1:0];
               ip_in = ip_ff + CW'(1);
            end else begin
               ip_in = ip_ff;
            end
            if (scan_hit) begin
               i_in = dp_ff;
               e_in = rd_data;
            end else if (scan_miss) begin
               if (phase_ff == ffha_pkg::PH_ALLOC) begin
                  fails_in  = fails_ff + W'(1);
                  res_st_in = ffha_pkg::ST_NOMEM;
               end else begin
                  res_st_in = ffha_pkg::ST_INVALID;
               end
            end
         end
         ffha_pkg::S_SPLIT_CHK: begin
            split_in = split_now;
            if (split_now) begin
               count_in  = count_ff + CW'(1);
               src_in    = IW'(count_ff - CW'(1));
               last_in   = i_ff + IW'(1);
               dir_up_in = 1'b1;
               more_in   = 1'b1;
            end
         end
         ffha_pkg::S_COPY: begin
            if (more_ff) begin
               pend_in = 1'b1;
               dst_in  = dir_up_ff ? (src_ff + IW'(1)) : (src_ff - gap_ff);
               if (src_ff == last_ff) more_in = 1'b0;
               else src_in = dir_up_ff ? (src_ff - IW'(1)) : (src_ff + IW'(1));
            end
         end
         ffha_pkg::S_WR_OLD: begin
            allocs_in   = allocs_ff + W'(1);
            res_addr_in = e_ff.offset + HDR;
            res_gr_in   = split_ff ? prep.rounded[AW-1:0] : e_ff.size;
            res_st_in   = ffha_pkg::ST_OK;
            if (grow_ff) phase_in = ffha_pkg::PH_FIND;
         end
         ffha_pkg::S_CHECK: begin
            if (e_ff.free) begin
               res_st_in = ffha_pkg::ST_DOUBLE;
            end else if (resize_path) begin
               if (fits) begin
                  res_addr_in = req_ff.address;
                  res_gr_in   = e_ff.size;
               end else begin
                  grow_in  = 1'b1;
                  phase_in = ffha_pkg::PH_ALLOC;
               end
            end else begin
               a_in     = i_ff;
               b_in     = i_ff;
               a_off_in = e_ff.offset;
               b_end_in = e_ff.offset + e_ff.size;
            end
         end
         ffha_pkg::S_BK_CHK: begin
            if (rd_data.free) begin
               a_in     = a_ff - IW'(1);
               a_off_in = rd_data.offset;
            end
         end
         ffha_pkg::S_FW_CHK: begin
            if (rd_data.free) begin
               b_in     = b_ff + IW'(1);
               b_end_in = rd_data.offset + rd_data.size;
            end
         end
         ffha_pkg::S_MERGE: begin
            if (b_ff > a_ff) begin
               gap_in    = b_ff - a_ff;
               count_in  = count_ff - CW'(b_ff - a_ff);
               src_in    = b_ff + IW'(1);
               last_in   = IW'(count_ff - CW'(1));
               dir_up_in = 1'b0;
               more_in   = 1'b1;
            end
         end
         ffha_pkg::S_FREE_END: frees_in = frees_ff + W'(1);
         ffha_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{result_address: res_addr_ff, status: res_st_ff,
                                granted_size: res_gr_ff, alloc_count: allocs_ff,
                                release_count: frees_ff, fail_count: fails_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_IDLE;
         count_ff     <= CW'(1);
         allocs_ff    <= '0;
         frees_ff     <= '0;
         fails_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
         ip_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         allocs_ff    <= allocs_in;
         frees_ff     <= frees_in;
         fails_ff     <= fails_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
         ip_ff        <= ip_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      req_ff      <= req_in;
      e_ff        <= e_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      res_gr_ff   <= res_gr_in;
      grow_ff     <= grow_in;
      split_ff    <= split_in;
      dp_ff       <= dp_in;
      i_ff        <= i_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      gap_ff      <= gap_in;
      a_off_ff    <= a_off_in;
      b_end_ff    <= b_end_in;
      src_ff      <= src_in;
      last_ff     <= last_in;
      dst_ff      <= dst_in;
      dir_up_ff   <= dir_up_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FFHA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
                     !req_ready, "ready held after an item was accepted")
   `FFHA_ASSERT_NOW(a_count_range, clock, reset, state_ff == ffha_pkg::S_IDLE,
                    (count_ff != '0) && (count_ff <= CW'(MAX_SEGMENTS)),
                    "segment count out of range")
   `FFHA_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == ffha_pkg::S_DONE, "result raised outside the done state")

endmodule
`default_nettype wire

/* hdl/ffha_seg_ram.sv */
// Segment table memory with registered read and a reset image for entry zero.
`default_nettype none
module ffha_seg_ram #(
   parameter int DEPTH = 64,
   parameter logic [20:0] RESET_SIZE = 21'd1048544
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  ffha_pkg::seg_type            wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output ffha_pkg::seg_type            rd_data
);

   ffha_pkg::seg_type mem [DEPTH];
   ffha_pkg::seg_type rd_q_ff;
   ffha_pkg::seg_type reset_image;
   logic              init_ff;
   logic              rd_init_ff;

   assign reset_image = '{offset: '0, size: RESET_SIZE, free: 1'b1};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= 1'b1;
         rd_init_ff <= 1'b0;
      end else begin
         rd_init_ff <= init_ff && (rd_addr == '0);
         if (wr_en && (wr_addr == '0)) begin
            init_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_init_ff ? reset_image : rd_q_ff;

endmodule
`default_nettype wire

/* hdl/ffha_prep.sv */
// Request preparation pipeline: calloc product, alignment rounding and split threshold.
`default_nettype none
module ffha_prep #(
   parameter int HEADER_BYTES   = 32,
   parameter int DEFAULT_ALIGN  = 16,
   parameter int MIN_SPLIT_DATA = 16
) (
   input  logic                   clock,
   input  ffha_pkg::req_item_type req,
   output ffha_pkg::prep_type     prep
);

   localparam int W = ffha_pkg::WORD_W;

   logic [2*W-1:0] prod_ff;
   logic [W-1:0]   size_ff;
   logic [W:0]     align_ff;
   logic           calloc_ff;
   logic [W:0]     align_in;
   logic [W:0]     rounded_ff;
   logic           zero_ff;
   logic           ovf_ff;
   logic [W-1:0]   eff_size;
   logic [W:0]     mask;
   logic [W+1:0]   need_ff;
   logic           zero2_ff;
   logic           ovf2_ff;
   logic [W:0]     rounded2_ff;

   always_comb begin
      align_in = (W+1)'(DEFAULT_ALIGN);
      if ((req.req_type == ffha_pkg::OP_ALLOC) && (req.alignment != '0) &&
          ((req.alignment & (req.alignment - W'(1))) == '0)) begin
         align_in = {1'b0, req.alignment};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= {{W{1'b0}}, req.count} * {{W{1'b0}}, req.size};
      size_ff   <= req.size;
      align_ff  <= align_in;
      calloc_ff <= (req.req_type == ffha_pkg::OP_CALLOC);
   end

   assign eff_size = calloc_ff ? prod_ff[W-1:0] : size_ff;
   assign mask     = align_ff - (W+1)'(1);

   always_ff @(posedge clock) begin
      rounded_ff <= ({1'b0, eff_size} + mask) & ~mask;
      zero_ff    <= (eff_size == '0);
      ovf_ff     <= calloc_ff && (prod_ff[2*W-1:W] != '0);
   end

   always_ff @(posedge clock) begin
      need_ff     <= {1'b0, rounded_ff} + (W+2)'(HEADER_BYTES + MIN_SPLIT_DATA);
      rounded2_ff <= rounded_ff;
      zero2_ff    <= zero_ff;
      ovf2_ff     <= ovf_ff;
   end

   assign prep = '{rounded: rounded2_ff, need: need_ff, zero: zero2_ff, ovf: ovf2_ff};

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the first-fit heap allocator: random and directed requests checked against a model.
`timescale 1ns / 100ps
`default_nettype none

class heap_scoreboard;
   localparam int HEAP = 1048576;
   localparam int HDR = 32;
   localparam int DEF_ALIGN = 16;
   localparam int MAX_SEG = 64;
   localparam int MIN_SPLIT = 16;

   bit [20:0] seg_base[MAX_SEG];
   bit [20:0] seg_len[MAX_SEG];
   bit seg_open[MAX_SEG];
   int unsigned seg_num;
   bit [31:0] n_alloc, n_free, n_fail;
   ffha_pkg::rsp_item_type pending[$];
   bit [20:0] live[$];
   int unsigned mismatches;

   function new();
      seg_base[0] = 0;
      seg_len[0] = HEAP - HDR;
      seg_open[0] = 1;
      seg_num = 1;
      n_alloc = 0;
      n_free = 0;
      n_fail = 0;
      mismatches = 0;
   endfunction

   function ffha_pkg::status_type grant(bit [31:0] sz, bit [31:0] al,
                                        output bit [20:0] addr, output bit [20:0] gs);
      longint unsigned a, r;
      int unsigned i;
      addr = 0;
      gs = 0;
      if (sz == 0) return ffha_pkg::ST_ZERO;
      a = al;
      if (a == 0 || (a & (a - 1)) != 0) a = DEF_ALIGN;
      r = (longint'(sz) + a - 1) & ~(a - 1);
      for (i = 0; i < seg_num; i++)
         if (seg_open[i] && seg_len[i] >= r) break;
      if (i >= seg_num) begin
         n_fail++;
         return ffha_pkg::ST_NOMEM;
      end
      if (seg_len[i] >= r + HDR + MIN_SPLIT && seg_num < MAX_SEG) begin
         for (int j = seg_num; j > i + 1; j--) begin
            seg_base[j] = seg_base[j-1];
            seg_len[j] = seg_len[j-1];
            seg_open[j] = seg_open[j-1];
         end
         seg_base[i+1] = seg_base[i] + HDR + r;
         seg_len[i+1] = seg_len[i] - r - HDR;
         seg_open[i+1] = 1;
         seg_len[i] = r;
         seg_num++;
      end
      seg_open[i] = 0;
      n_alloc++;
      addr = seg_base[i] + HDR;
      gs = seg_len[i];
      live.push_back(addr);
      return ffha_pkg::ST_OK;
   endfunction

   function int lookup(bit [20:0] addr);
      for (int i = 0; i < seg_num; i++)
         if (seg_base[i] + HDR == addr) return i;
      return -1;
   endfunction

   function ffha_pkg::status_type release_seg(bit [20:0] addr);
      int i, a, b, g;
      if (addr == 0) return ffha_pkg::ST_OK;
      i = lookup(addr);
      if (i < 0) return ffha_pkg::ST_INVALID;
      if (seg_open[i]) return ffha_pkg::ST_DOUBLE;
      seg_open[i] = 1;
      a = i;
      while (a > 0 && seg_open[a-1]) a--;
      b = i;
      while (b + 1 < seg_num && seg_open[b+1]) b++;
      if (b > a) begin
         seg_len[a] = seg_base[b] + seg_len[b] - seg_base[a];
         g = b - a;
         for (int k = b + 1; k < seg_num; k++) begin
            seg_base[k-g] = seg_base[k];
            seg_len[k-g] = seg_len[k];
            seg_open[k-g] = seg_open[k];
         end
         seg_num -= g;
      end
      n_free++;
      return ffha_pkg::ST_OK;
   endfunction

   function void note_request(ffha_pkg::req_item_type rq);
      bit [20:0] addr, gs;
      ffha_pkg::status_type st;
      longint unsigned prod;
      int idx;
      ffha_pkg::rsp_item_type e;
      addr = 0;
      gs = 0;
      st = ffha_pkg::ST_OK;
      case (rq.req_type)
         ffha_pkg::OP_ALLOC: st = grant(rq.size, rq.alignment, addr, gs);
         ffha_pkg::OP_CALLOC: begin
            prod = longint'(rq.count) * longint'(rq.size);
            if (prod > 64'hFFFF_FFFF) begin
               n_fail++;
               st = ffha_pkg::ST_OVERFLOW;
            end else st = grant(prod[31:0], DEF_ALIGN, addr, gs);
         end
         ffha_pkg::OP_FREE: st = release_seg(rq.address);
         default: begin
            idx = lookup(rq.address);
            if (rq.address == 0) st = grant(rq.size, DEF_ALIGN, addr, gs);
            else if (rq.size == 0) st = release_seg(rq.address);
            else if (idx < 0) st = ffha_pkg::ST_INVALID;
            else if (seg_open[idx]) st = ffha_pkg::ST_DOUBLE;
            else if (rq.size <= seg_len[idx]) begin
               addr = rq.address;
               gs = seg_len[idx];
            end else begin
               st = grant(rq.size, DEF_ALIGN, addr, gs);
               if (st == ffha_pkg::ST_OK) void'(release_seg(rq.address));
            end
         end
      endcase
      if (st != ffha_pkg::ST_OK) begin
         addr = 0;
         gs = 0;
      end
      e.result_address = addr;
      e.status = st;
      e.granted_size = gs;
      e.alloc_count = n_alloc;
      e.release_count = n_free;
      e.fail_count = n_fail;
      pending.push_back(e);
   endfunction

   function void check_result(ffha_pkg::rsp_item_type got);
      ffha_pkg::rsp_item_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result item %p.", got);
         return;
      end
      e = pending.pop_front();
      if (got.result_address !== e.result_address || got.status !== e.status ||
          got.granted_size !== e.granted_size || got.alloc_count !== e.alloc_count ||
          got.release_count !== e.release_count || got.fail_count !== e.fail_count) begin
         mismatches++;
         if (mismatches <= 10) $display("Mismatch: expected %p, got %p.", e, got);
      end
   endfunction
endclass

module tb_top;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   ffha_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   ffha_pkg::rsp_item_type rsp_item;

   heap_scoreboard board = new();
   int unsigned cycles = 0;
   bit quiet = 0;
   bit wild_rsp = 0;

   first_fit_heap_allocator uut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_item);
      if (req_valid && req_ready) board.note_request(req_item);
   end

   initial begin : rsp_side
      int n;
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send(ffha_pkg::req_item_type it);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic ffha_pkg::req_item_type pick(ffha_pkg::op_type op, bit [31:0] sz,
                                                   bit [31:0] al, bit [31:0] cn,
                                                   bit [20:0] ad);
      ffha_pkg::req_item_type it;
      it.req_type = op;
      it.size = sz;
      it.alignment = al;
      it.count = cn;
      it.address = ad;
      return it;
   endfunction

   function automatic bit [31:0] any_size();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 4);
         2: return $urandom_range(1, 200000);
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   function automatic bit [20:0] any_addr();
      int q;
      q = board.live.size();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 0;
         default: return q ? board.live[$urandom_range(0, q - 1)] : 21'd32;
      endcase
   endfunction

   initial begin : stim
      ffha_pkg::req_item_type it;
      int t;
      bit [31:0] al;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(pick(ffha_pkg::OP_ALLOC, 0, 0, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 1, 0, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 100, 64, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 100, 3, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 1048576 - 32, 1, 0, 0));
      send(pick(ffha_pkg::OP_CALLOC, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
      send(pick(ffha_pkg::OP_CALLOC, 0, 0, 5, 0));
      send(pick(ffha_pkg::OP_CALLOC, 8, 0, 8, 0));
      send(pick(ffha_pkg::OP_FREE, 0, 0, 0, 0));
      send(pick(ffha_pkg::OP_FREE, 0, 0, 0, 21'h1F_FFFF));
      send(pick(ffha_pkg::OP_FREE, 0, 0, 0, 32));
      send(pick(ffha_pkg::OP_FREE, 0, 0, 0, 32));
      send(pick(ffha_pkg::OP_REALLOC, 50, 0, 0, 0));
      send(pick(ffha_pkg::OP_REALLOC, 10, 0, 0, 32));
      send(pick(ffha_pkg::OP_REALLOC, 5000, 0, 0, board.live[$]));
      send(pick(ffha_pkg::OP_REALLOC, 1, 0, 0, board.live[$]));
      send(pick(ffha_pkg::OP_REALLOC, 0, 0, 0, board.live[$]));
      send(pick(ffha_pkg::OP_REALLOC, 4, 0, 0, 21'd1048576));
      for (int k = 0; k < 70; k++) send(pick(ffha_pkg::OP_ALLOC, 16, 0, 0, 0));
      send(pick(ffha_pkg::OP_ALLOC, 1000000, 0, 0, 0));
      for (int k = 0; k < 710; k++) begin
         if (k > 640) quiet = 1;
         t = $urandom_range(0, 9);
         al = $urandom_range(0, 3) == 0 ? $urandom : 32'd1 << $urandom_range(0, 12);
         if (t < 4) it = pick(ffha_pkg::OP_ALLOC, any_size(), al, $urandom, $urandom);
         else if (t < 5) it = pick(ffha_pkg::OP_CALLOC,
                                   $urandom_range(0, 3) ? $urandom_range(0, 300) : $urandom,
                                   $urandom,
                                   $urandom_range(0, 3) ? $urandom_range(0, 64) : $urandom,
                                   $urandom);
         else if (t < 8) it = pick(ffha_pkg::OP_FREE, $urandom, $urandom, $urandom,
                                   any_addr());
         else it = pick(ffha_pkg::OP_REALLOC, any_size(), $urandom, $urandom, any_addr());
         send(it);
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
